// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the shuffler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
// Types and constants of the seeded permutation shuffler.
package sps_pkg;

  // Field and port widths.
  localparam int SEED_W      = 64;
  localparam int COUNT_W     = 13;
  localparam int POS_W       = 12;
  localparam int ELEM_W      = 12;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

  // SplitMix64 constants.
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
  localparam int          MIX_SH_A    = 30;
  localparam int          MIX_SH_B    = 27;
  localparam int          MIX_SH_C    = 31;

  // Item kinds.
  typedef enum logic {
    OP_START = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_RANGE        = 2'd1,
    ST_NOT_SHUFFLED = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_FLOOR,
    S_FLOOR_W,
    S_GEN,
    S_MIX1,
    S_MIX1_W,
    S_MIX2,
    S_MIX2_W,
    S_CHECK,
    S_MOD_W,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_RESP
  } state_t;

endpackage

// ----- rtl/sps_mul.sv -----
// Iterative 64x64 multiplier giving the low 64 product bits from one 32x32 multiplier.
`include "assert_macros.svh"
module sps_mul import sps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        busy,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;
  localparam logic [1:0] STEP_FIN = 2'd3;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [63:0] a_r, b_r;
  logic [63:0] p_r, p_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] op_x, op_y;

  // Operand selection for the shared 32x32 multiplier.
  always_comb begin
    case (step_r)
      STEP_LL: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
      STEP_LH: begin
        op_x = a_r[31:0];
        op_y = b_r[63:32];
      end
      STEP_HL: begin
        op_x = a_r[63:32];
        op_y = b_r[31:0];
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  // Registered partial product, accumulated one step later.
  always_comb begin
    p_nxt    = op_x * op_y;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_LL;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        STEP_LH: acc_nxt = p_r;
        STEP_HL: acc_nxt[63:32] = acc_r[63:32] + p_r[31:0];
        STEP_FIN: begin
          acc_nxt[63:32] = acc_r[63:32] + p_r[31:0];
          busy_nxt       = 1'b0;
          done_nxt       = 1'b1;
        end
        default: acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_LL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    p_r   <= p_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

  `SPS_ASSERT_IMP(a_mul_done_after_busy, clk, rst_n, done_r, $past(busy_r), "product done without a running multiply")

endmodule

// ----- rtl/sps_rem.sv -----
// Bit-serial remainder unit: 64-bit dividend modulo a narrow divisor, one bit a cycle.
`include "assert_macros.svh"
module sps_rem import sps_pkg::*; #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int STEPS = 64;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      q_r, q_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    d_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial    = {rem_r, q_r[63]};
    diff     = trial - {1'b0, d_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[62:0], 1'b0};
      rem_nxt = (trial >= {1'b0, d_r}) ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

  `SPS_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, done_r, rem_r < d_r, "remainder not below divisor")

endmodule

// ----- rtl/seeded_permutation_shuffler.sv -----
// Top level of the seeded permutation shuffler: sequencer, table memory and result register.
//
// Use: configuration writes on cfg_* set the seed (index 0) and count (index 1); write them
// only while the block is idle. Items enter on in_*: in_tuser selects start or read, and
// in_tdata[11:0] carries the position. Every item gives one result on out_*: out_tdata[11:0]
// is the element and out_tuser the status (0 ok, 1 out of range, 2 not yet shuffled).
// A read result is registered through the S_RESP state into the output register, and
// in_tready rises at the same time as out_tvalid. A start fills n table entries (one a cycle)
// and then runs n-1 swap steps: the rejection floor on the bit-serial remainder unit,
// one draw (the generator step, two 64-bit multiplies on the shared multiplier and the
// accept check), the reduction on the remainder unit, and a table read and two table
// writes; a rejected draw repeats the draw. The block takes one item at a time; in_tready
// is high only while it is idle. A finished result waits in the output register while
// out_tready is low; the next item may still be taken, but its result holds the block
// until the earlier one has been transferred.
// Reset clears seed, count, the shuffled flag and the result valid flag; the table contents
// are undefined until the first start. No clearing pass is run.
`include "assert_macros.svh"
module seeded_permutation_shuffler import sps_pkg::*; #(
  parameter int MAX_ELEMENTS = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SEED_W-1:0]      cfg_data,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] position, [15:12] zero
  input  logic [0:0]             in_tuser,   // [0] op
  // Results.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [11:0] element, [15:12] zero
  output logic [STAT_W-1:0]      out_tuser   // [1:0] status
);

  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int N_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int CW   = (N_W > COUNT_W) ? N_W : COUNT_W;
  localparam int EW   = (AW > ELEM_W) ? AW : ELEM_W;

  // Control registers.
  state_t               state_r, state_nxt;
  logic                 shuffled_r, shuffled_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SEED_W-1:0]    seed_r;
  logic [COUNT_W-1:0]   count_r;

  // Payload registers.
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [63:0]          gen_r, gen_nxt;
  logic [63:0]          z_r, z_nxt;
  logic [CW-1:0]        floor_r, floor_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  status_t              status_r, status_nxt;
  logic                 rd_item_r, rd_item_nxt;
  logic [ELEM_W-1:0]    out_elem_r, out_elem_nxt;
  status_t              out_status_r, out_status_nxt;

  // Table memory.
  logic [AW-1:0]        mem [MAX_ELEMENTS];
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_wdata, mem_ra, mem_rb;
  logic [AW-1:0]        rda_r, rdb_r;

  // Shared units.
  logic                 rem_start, rem_busy, rem_done;
  logic [63:0]          rem_dividend;
  logic [CW-1:0]        rem_res;
  logic                 mul_start, mul_busy, mul_done;
  logic [63:0]          mul_a, mul_b, mul_prod;

  // Decoded input and helpers.
  logic                 in_xfer, cfg_xfer, out_load;
  op_t                  in_op;
  logic [EW-1:0]        pos_full;
  logic [CW-1:0]        count_ext, n_live;
  logic [AW-1:0]        im1_addr;
  logic [EW-1:0]        elem_full;
  logic [63:0]          mix_p;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser[0]);
  assign pos_full  = EW'(in_tdata[POS_W-1:0]);
  assign count_ext = CW'(count_r);
  assign n_live    = (count_ext > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : count_ext;
  assign im1_addr  = AW'(i_r - CW'(1));
  assign elem_full = EW'(rda_r);
  assign mix_p     = mul_prod ^ (mul_prod >> MIX_SH_C);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_tready);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_START && n_live != '0) begin
            state_nxt = S_FILL;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_FILL: begin
        if (idx_r == n_r - CW'(1)) begin
          state_nxt = (n_r < CW'(2)) ? S_RESP : S_FLOOR;
        end
      end
      S_FLOOR:   state_nxt = S_FLOOR_W;
      S_FLOOR_W: if (rem_done) state_nxt = S_GEN;
      S_GEN:     state_nxt = S_MIX1;
      S_MIX1:    state_nxt = S_MIX1_W;
      S_MIX1_W:  if (mul_done) state_nxt = S_MIX2;
      S_MIX2:    state_nxt = S_MIX2_W;
      S_MIX2_W:  if (mul_done) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = (z_r >= 64'(floor_r)) ? S_MOD_W : S_GEN;
      S_MOD_W:   if (rem_done) state_nxt = S_SWAP_RD;
      S_SWAP_RD: state_nxt = S_SWAP_WA;
      S_SWAP_WA: state_nxt = S_SWAP_WB;
      S_SWAP_WB: state_nxt = (i_r == CW'(2)) ? S_RESP : S_FLOOR;
      S_RESP:    if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control outputs to the memory and the shared units.
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_ra       = '0;
    mem_rb       = '0;
    rem_start    = 1'b0;
    rem_dividend = z_r;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      S_IDLE: begin
        mem_re = in_xfer && (in_op == OP_READ);
        mem_ra = pos_full[AW-1:0];
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = idx_r[AW-1:0];
      end
      S_FLOOR: begin
        rem_start    = 1'b1;
        rem_dividend = 64'd0 - 64'(i_r);
      end
      S_MIX1: begin
        mul_start = 1'b1;
        mul_a     = gen_r ^ (gen_r >> MIX_SH_A);
        mul_b     = MIX_MUL_A;
      end
      S_MIX2: begin
        mul_start = 1'b1;
        mul_a     = z_r ^ (z_r >> MIX_SH_B);
        mul_b     = MIX_MUL_B;
      end
      S_CHECK: begin
        rem_start = (z_r >= 64'(floor_r));
      end
      S_SWAP_RD: begin
        mem_re = 1'b1;
        mem_ra = im1_addr;
        mem_rb = j_r;
      end
      S_SWAP_WA: begin
        mem_we    = 1'b1;
        mem_waddr = im1_addr;
        mem_wdata = rdb_r;
      end
      S_SWAP_WB: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = rda_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    i_nxt          = i_r;
    gen_nxt        = gen_r;
    z_nxt          = z_r;
    floor_nxt      = floor_r;
    j_nxt          = j_r;
    status_nxt     = status_r;
    rd_item_nxt    = rd_item_r;
    shuffled_nxt   = shuffled_r;
    out_elem_nxt   = out_elem_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_START) begin
            n_nxt        = n_live;
            i_nxt        = n_live;
            idx_nxt      = '0;
            gen_nxt      = seed_r;
            status_nxt   = ST_OK;
            rd_item_nxt  = 1'b0;
            shuffled_nxt = 1'b1;
          end else begin
            rd_item_nxt = 1'b1;
            if (!shuffled_r) begin
              status_nxt = ST_NOT_SHUFFLED;
            end else if (CW'(in_tdata[POS_W-1:0]) >= n_live) begin
              status_nxt = ST_RANGE;
            end else begin
              status_nxt = ST_OK;
            end
          end
        end
      end
      S_FILL:    idx_nxt = idx_r + CW'(1);
      S_FLOOR_W: if (rem_done) floor_nxt = rem_res;
      S_GEN:     gen_nxt = gen_r + GOLDEN_STEP;
      S_MIX1_W:  if (mul_done) z_nxt = mul_prod;
      S_MIX2_W:  if (mul_done) z_nxt = mix_p;
      S_MOD_W:   if (rem_done) j_nxt = rem_res[AW-1:0];
      S_SWAP_WB: i_nxt = i_r - CW'(1);
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_elem_nxt   = (rd_item_r && status_r == ST_OK) ? elem_full[ELEM_W-1:0] : '0;
        end
      end
      default: begin
        n_nxt = n_r;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shuffled_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      shuffled_r  <= shuffled_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_xfer && cfg_index == REG_SEED) begin
        seed_r <= cfg_data;
      end
      if (cfg_xfer && cfg_index == REG_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    i_r          <= i_nxt;
    gen_r        <= gen_nxt;
    z_r          <= z_nxt;
    floor_r      <= floor_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    rd_item_r    <= rd_item_nxt;
    out_elem_r   <= out_elem_nxt;
    out_status_r <= out_status_nxt;
  end

  // Table memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rda_r <= mem[mem_ra];
      rdb_r <= mem[mem_rb];
    end
  end

  // Shared remainder unit, used for the rejection floor and the reduction.
  sps_rem #(
    .DW (CW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (i_r),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_res)
  );

  // Shared multiplier for both mixing steps.
  sps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ELEM_W){1'b0}}, out_elem_r};
  assign out_tuser  = out_status_r;

  `SPS_ASSERT_IMP(a_units_idle, clk, rst_n, in_tready, !rem_busy && !mul_busy, "shared unit busy while idle")
  `SPS_ASSERT_IMP(a_partner_below_i, clk, rst_n, state_r == S_SWAP_RD, CW'(j_r) < i_r, "swap partner not below bound")
  `SPS_ASSERT_NXT(a_resp_loads_out, clk, rst_n, out_load, out_tvalid, "result not presented after load")

endmodule

// ----- dv/tb_seeded_permutation_shuffler.sv -----
// Self-checking testbench for the seeded permutation shuffler.
module tb_seeded_permutation_shuffler;
  import sps_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  // Index values beyond the two defined registers; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    op_t             op;
    logic [POS_W-1:0] position;
  } shuffle_cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    status_t           status;
  } lookup_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SEED_W-1:0]      cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [11:0] position, [15:12] zero
  logic [0:0]             in_tuser = '0;   // [0] op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [11:0] element, [15:12] zero
  logic [STAT_W-1:0]      out_tuser;       // [1:0] status

  // Items waiting for the driver, and lookups waiting for their result transfer.
  shuffle_cmd_t pending_cmds[$];
  lookup_t      expected_lookups[$];
  shuffle_cmd_t next_cmd;
  int           items_queued = 0;
  int           items_accepted = 0;
  int           fail_count = 0;

  // Idle controls, set per phase by the stimulus process.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_left = 0;

  // Predictor state: register copies, the permutation table and the generator.
  logic [SEED_W-1:0]  seed_copy = '0;
  logic [COUNT_W-1:0] count_copy = '0;
  logic [63:0]        gen_state = '0;
  logic [ELEM_W-1:0]  perm_model[TABLE_DEPTH];
  bit                 shuffled_flag = 1'b0;

  seeded_permutation_shuffler #(.MAX_ELEMENTS(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count limited to the table depth.
  function automatic int live_count();
    return (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy);
  endfunction

  // One SplitMix64 output; advances the generator.
  function automatic logic [63:0] splitmix_next();
    logic [63:0] z;
    gen_state = gen_state + GOLDEN_STEP;
    z = gen_state;
    z = (z ^ (z >> MIX_SH_A)) * MIX_MUL_A;
    z = (z ^ (z >> MIX_SH_B)) * MIX_MUL_B;
    return z ^ (z >> MIX_SH_C);
  endfunction

  // Unbiased draw below bound: draws under (2^64 - bound) mod bound are rejected.
  function automatic logic [63:0] draw_below(logic [63:0] bound);
    logic [63:0] floor_v;
    logic [63:0] r;
    floor_v = (64'd0 - bound) % bound;
    do r = splitmix_next(); while (r < floor_v);
    return r % bound;
  endfunction

  // Identity fill followed by a Fisher-Yates pass from the top down.
  function automatic void shuffle_table(int n);
    int i;
    int j;
    logic [ELEM_W-1:0] tmp;
    gen_state = seed_copy;
    for (i = 0; i < n; i++) perm_model[i] = ELEM_W'(i);
    for (i = n; i > 1; i--) begin
      j = int'(draw_below(64'(i)));
      tmp = perm_model[i-1];
      perm_model[i-1] = perm_model[j];
      perm_model[j] = tmp;
    end
    shuffled_flag = 1'b1;
  endfunction

  // Expected result of one accepted item; a start also updates the table.
  function automatic lookup_t predict_lookup(op_t op, logic [POS_W-1:0] pos);
    lookup_t res;
    int n;
    n = live_count();
    res.element = '0;
    res.status = ST_OK;
    if (op == OP_START) begin
      shuffle_table(n);
    end else if (!shuffled_flag) begin
      res.status = ST_NOT_SHUFFLED;
    end else if (int'(pos) >= n) begin
      res.status = ST_RANGE;
    end else begin
      res.element = perm_model[pos];
    end
    return res;
  endfunction

  // Driver: presents the next pending item once the previous one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_cmd.op;
        in_tdata <= {{(IN_TDATA_W-POS_W){1'b0}}, next_cmd.position};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off while rx_hold_left runs down.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: tracks register writes, checks each result transfer, predicts each item.
  always @(posedge clk) begin
    lookup_t want;
    lookup_t pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SEED:  seed_copy = cfg_data;
          REG_COUNT: count_copy = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          $error("result with no item pending: element %0d status %0d",
                 out_tdata[ELEM_W-1:0], out_tuser);
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_tdata[ELEM_W-1:0] !== want.element) begin
            $error("element mismatch: expected %0d, got %0d",
                   want.element, out_tdata[ELEM_W-1:0]);
            fail_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pred = predict_lookup(op_t'(in_tuser), in_tdata[POS_W-1:0]);
        expected_lookups = {expected_lookups, pred};
        items_accepted++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(input op_t op, input logic [POS_W-1:0] pos);
    shuffle_cmd_t c;
    c.op = op;
    c.position = pos;
    pending_cmds = {pending_cmds, c};
    items_queued++;
  endtask

  // Sender pause: wait until every queued item has transferred and every result has come.
  task automatic wait_drained();
    while (items_accepted != items_queued || expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random phase: fresh seed and count, then a first start and a mix of starts and reads, or reads only.
  task automatic random_segment(input int n_items, input int tx_pct, input int rx_pct,
                                input bit long_hold);
    logic [SEED_W-1:0] data;
    int cnt;
    int live;
    int k;
    int pick;
    int p;
    bit reads_only;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    write_reg(REG_SEED, {$urandom, $urandom});
    // Large counts are only read against; starting on them would cost too many cycles.
    // A long receiver hold-off runs on reads only, so that results pile up and stall input.
    reads_only = long_hold || ($urandom_range(3) == 0);
    cnt = reads_only ? $urandom_range(8191) : $urandom_range(32);
    data = {$urandom, $urandom};
    data[COUNT_W-1:0] = cnt[COUNT_W-1:0];
    write_reg(REG_COUNT, data);
    live = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (!reads_only && (k == 0 || pick < 6)) begin
        queue_item(OP_START, POS_W'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (live != 0 && pick < 60) begin
          p = $urandom_range(live - 1);
        end else if (pick < 80) begin
          // Around the top of the valid range.
          p = live - 1 + $urandom_range(2);
          if (p < 0) p = 0;
          if (p > TABLE_DEPTH - 1) p = TABLE_DEPTH - 1;
        end else begin
          p = $urandom_range(TABLE_DEPTH - 1);
        end
        queue_item(OP_READ, POS_W'(p));
      end
    end
    if (long_hold) rx_hold_left = 400;
    wait_drained();
  endtask

  initial begin
    int seg;
    int tx_modes[4];
    int rx_modes[4];
    tx_modes = '{0, 45, 0, 24};
    rx_modes = '{0, 0, 45, 24};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads before any start report not shuffled.
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd4095);
    wait_drained();
    write_reg(REG_UNUSED_2, {$urandom, $urandom});
    write_reg(REG_UNUSED_3, {$urandom, $urandom});

    // Start with count zero: shuffled, but every position is out of range.
    queue_item(OP_START, 12'd4095);
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd4095);
    wait_drained();

    // Count of one: no swap.
    write_reg(REG_COUNT, 64'd1);
    queue_item(OP_START, 12'd0);
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd1);
    wait_drained();

    // Count beyond the table depth with an all-ones seed; this writes every entry.
    write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_COUNT, 64'd8191);
    queue_item(OP_START, 12'd0);
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd4095);
    queue_item(OP_READ, 12'd2048);
    queue_item(OP_READ, 12'd1);
    wait_drained();

    // Small shuffle, then reads at and beyond its top.
    write_reg(REG_SEED, {$urandom, $urandom});
    write_reg(REG_COUNT, 64'd5);
    queue_item(OP_START, 12'd0);
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd2);
    queue_item(OP_READ, 12'd4);
    queue_item(OP_READ, 12'd5);
    queue_item(OP_READ, 12'd4095);
    wait_drained();

    // Count raised without a start: upper positions return stale entries.
    write_reg(REG_COUNT, 64'd4096);
    queue_item(OP_READ, 12'd5);
    queue_item(OP_READ, 12'd4095);
    wait_drained();

    // Back-to-back starts on count two.
    write_reg(REG_COUNT, 64'd2);
    queue_item(OP_START, 12'd0);
    queue_item(OP_START, 12'd4095);
    queue_item(OP_READ, 12'd0);
    queue_item(OP_READ, 12'd1);
    queue_item(OP_READ, 12'd2);
    wait_drained();

    // Random phases over all idle modes; the first one holds the receiver off for long.
    for (seg = 0; seg < 8; seg++) begin
      random_segment(115, tx_modes[seg % 4], rx_modes[seg % 4], seg == 0);
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #12_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
